FILE: design/tea16_pkg.sv
`timescale 1ns / 1ps

package tea16_pkg;

  localparam int ROUNDS = 16;
  localparam int STAGES = 2 * ROUNDS;

  localparam int WORD_W    = 32;
  localparam int TDATA_W   = 2 * WORD_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = CFG_IDX_W'(3);

  // direction codes
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] k3;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k0;
  } key_t;

  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } blk_t;

  // running sum after n additions of the delta, mod 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int n);
    logic [2*WORD_W-1:0] p;
    p = (2*WORD_W)'(n) * (2*WORD_W)'(DELTA);
    return p[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] w,
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

endpackage

FILE: design/tea16_block_cipher.sv
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------
// in_      | in_tvalid/in_tready | tuser: cmd; tdata: word_low, word_high
// out_     | out_tvalid/out_tready | tdata: out_low, out_high
// cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data (key words 0..3)
//
// one block enters per cycle while the output is not stalled; each block
// passes through the row of half-round cells in order, the last cell being
// the output register
// the whole row moves as one: it advances when the output is empty or taken,
// so a stalled output freezes every cell and drops in_tready
// rst_n is synchronous, active low: clears valid bits and the key words
// cfg_ready is always high; the user must change keys only while the row is empty, the block does not enforce it

module tea16_block_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tea16_pkg::TDATA_W-1:0]   in_tdata,   // word_low, word_high
  input  logic                            in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tea16_pkg::TDATA_W-1:0]   out_tdata,  // out_low, out_high
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tea16_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tea16_pkg::WORD_W-1:0]    cfg_data
);
  import tea16_pkg::*;

  key_t keys;
  blk_t chain [STAGES+1];
  logic adv;

  assign cfg_ready = 1'b1;

  tea16_keys u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .keys     (keys)
  );

  // whole row steps together whenever the last cell can hand off
  assign adv       = !chain[STAGES].vld || out_tready;
  assign in_tready = adv;

  always_comb begin
    chain[0].vld = in_tvalid;
    chain[0].cmd = in_tuser;
    chain[0].x   = in_tdata[WORD_W-1:0];
    chain[0].y   = in_tdata[TDATA_W-1:WORD_W];
  end

  // cell k works on round k/2; the sum constants for that round are tied on
  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    localparam logic [WORD_W-1:0] SUM_ENC = round_sum(k / 2 + 1);
    localparam logic [WORD_W-1:0] SUM_DEC = round_sum(ROUNDS - k / 2);
    localparam logic              ODD     = 1'(k % 2);

    tea16_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .odd     (ODD),
      .sum_enc (SUM_ENC),
      .sum_dec (SUM_DEC),
      .keys    (keys),
      .blk_i   (chain[k]),
      .blk_o   (chain[k+1])
    );
  end

  assign out_tvalid = chain[STAGES].vld;
  assign out_tdata  = {chain[STAGES].y, chain[STAGES].x};

endmodule

FILE: design/tea16_keys.sv
`timescale 1ns / 1ps

module tea16_keys (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [tea16_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tea16_pkg::WORD_W-1:0]    wr_data,
  output tea16_pkg::key_t            keys
);
  import tea16_pkg::*;

  key_t key_r;
  key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_KEY0: key_nxt.k0 = wr_data;
        REG_KEY1: key_nxt.k1 = wr_data;
        REG_KEY2: key_nxt.k2 = wr_data;
        REG_KEY3: key_nxt.k3 = wr_data;
        default:  key_nxt = key_r; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign keys = key_r;

endmodule

FILE: design/tea16_cell.sv
`timescale 1ns / 1ps

module tea16_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         odd,
  input  logic [tea16_pkg::WORD_W-1:0] sum_enc,
  input  logic [tea16_pkg::WORD_W-1:0] sum_dec,
  input  tea16_pkg::key_t              keys,
  input  tea16_pkg::blk_t              blk_i,
  output tea16_pkg::blk_t              blk_o
);
  import tea16_pkg::*;

  blk_t              blk_r;
  blk_t              blk_nxt;
  logic              upd_x;
  logic [WORD_W-1:0] s;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] m;
  logic [WORD_W-1:0] res;

  // encrypt: even half updates x, odd updates y; decrypt the other way round
  always_comb begin
    upd_x   = (blk_i.cmd == odd);
    s       = (blk_i.cmd == CMD_DEC) ? sum_dec : sum_enc;
    src     = upd_x ? blk_i.y : blk_i.x;
    dst     = upd_x ? blk_i.x : blk_i.y;
    ka      = upd_x ? keys.k0 : keys.k2;
    kb      = upd_x ? keys.k1 : keys.k3;
    m       = mix(src, s, ka, kb);
    res     = (blk_i.cmd == CMD_DEC) ? (dst - m) : (dst + m);
    blk_nxt = blk_i;
    if (upd_x) begin
      blk_nxt.x = res;
    end else begin
      blk_nxt.y = res;
    end
  end

  // only the valid bit is reset; the payload just follows the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r.vld <= 1'b0;
    end else if (adv) begin
      blk_r.vld <= blk_nxt.vld;
    end
    if (adv) begin
      blk_r.cmd <= blk_nxt.cmd;
      blk_r.x   <= blk_nxt.x;
      blk_r.y   <= blk_nxt.y;
    end
  end

  assign blk_o = blk_r;

endmodule

FILE: design/tea16_checker.sv
`timescale 1ns / 1ps

module tea16_protocol_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tea16_pkg::TDATA_W-1:0]   out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // a result waiting on a stall stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input is taken exactly when the output side can move
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track output stall");

  // reset empties the row
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // key writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind tea16_block_cipher tea16_protocol_checker u_tea16_checker (.*);
